/* hw/rtl/two_stage_moving_average_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the two-stage moving average unit
// Shared helpers that write clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef TWO_STAGE_MOVING_AVERAGE_UNIT_MACROS_SVH
`define TWO_STAGE_MOVING_AVERAGE_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TSMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsma assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TSMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsma assertion failed");

`endif

/* hw/rtl/tsma_pkg.sv */
// ----------------------------------------------------------------------------
// tsma_pkg
// Sizes, reciprocal constants, register map and types of the two-stage
// moving average unit.
// ----------------------------------------------------------------------------
package tsma_pkg;

	localparam int LONG_WINDOW  = 50;
	localparam int SHORT_WINDOW = 10;
	localparam int SAMPLE_BITS  = 16;

	// Running sums never overflow: window * max sample fits these widths.
	localparam int LONG_SUM_BITS  = SAMPLE_BITS + $clog2(LONG_WINDOW);
	localparam int SHORT_SUM_BITS = SAMPLE_BITS + $clog2(SHORT_WINDOW);

	// Division by a window length is a multiply by a rounded-up reciprocal.
	// With this shift the error stays below one part in the window, so the
	// truncated quotient is exact for every reachable sum.
	localparam int LONG_SHIFT       = LONG_SUM_BITS + $clog2(LONG_WINDOW);
	localparam int LONG_RECIP_BITS  = LONG_SHIFT - $clog2(LONG_WINDOW) + 1;
	localparam int LONG_PROD_BITS   = LONG_SUM_BITS + LONG_RECIP_BITS;
	localparam logic [LONG_RECIP_BITS-1:0] LONG_RECIP =
		LONG_RECIP_BITS'(((64'd1 << LONG_SHIFT) + 64'(LONG_WINDOW) - 64'd1)
		/ 64'(LONG_WINDOW));

	localparam int SHORT_SHIFT      = SHORT_SUM_BITS + $clog2(SHORT_WINDOW);
	localparam int SHORT_RECIP_BITS = SHORT_SHIFT - $clog2(SHORT_WINDOW) + 1;
	localparam int SHORT_PROD_BITS  = SHORT_SUM_BITS + SHORT_RECIP_BITS;
	localparam logic [SHORT_RECIP_BITS-1:0] SHORT_RECIP =
		SHORT_RECIP_BITS'(((64'd1 << SHORT_SHIFT) + 64'(SHORT_WINDOW) - 64'd1)
		/ 64'(SHORT_WINDOW));

	// Configuration port.
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_READING_BITS = 16;
	localparam logic CFG_IDX_DEFAULT_READING = 1'b0;
	localparam logic [CFG_READING_BITS-1:0] DEFAULT_READING_RESET = 16'd14080;

	// Command opcodes.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LMUL  = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_SMUL  = 5'b01000,
		ST_DONE  = 5'b10000
	} tsma_state_t;

endpackage

/* hw/rtl/tsma_cell.sv */
// ----------------------------------------------------------------------------
// tsma_cell
// One window entry: loads its left neighbor's value on a shift.
// ----------------------------------------------------------------------------
module tsma_cell import tsma_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift,
	input  sample_t d,
	output sample_t q
);

	sample_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

/* hw/rtl/tsma_cfg.sv */
// ----------------------------------------------------------------------------
// tsma_cfg
// APB-style register file holding the default reading.
// ----------------------------------------------------------------------------
module tsma_cfg import tsma_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [CFG_ADDR_BITS-1:0]    paddr,
	input  logic [CFG_DATA_BITS-1:0]    pwdata,
	output logic [CFG_DATA_BITS-1:0]    prdata,
	output logic                        pready,
	output logic [CFG_READING_BITS-1:0] default_reading
);

	logic [CFG_READING_BITS-1:0] default_reading_q;
	logic                        hit;

	// Registers sit on word addresses; the word index is the upper bit.
	assign hit = (paddr[CFG_ADDR_BITS-1] == CFG_IDX_DEFAULT_READING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_reading_q <= DEFAULT_READING_RESET;
		end else if (psel && penable && pwrite && hit) begin
			default_reading_q <= pwdata[CFG_READING_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = CFG_DATA_BITS'(default_reading_q);
		end
	end

	assign pready          = 1'b1;
	assign default_reading = default_reading_q;

endmodule

/* hw/rtl/two_stage_moving_average_unit.sv */
// ----------------------------------------------------------------------------
// two_stage_moving_average_unit
// Cascaded moving-average filter for Q10.6 voltage samples.
// ----------------------------------------------------------------------------
// A push transaction (opcode 0) shifts one sample into a chain of 50 cells,
// and pushes can arrive back to back while no read is in flight. A read
// transaction (opcode 1) passes through these steps before its result is
// loaded into the output register: the reciprocal multiply that divides the
// long running sum by 50, the shift of that mean into a chain of 10 cells,
// the reciprocal multiply that divides the short running sum by 10, and the
// forming of the result. cmd_stall is high while a read is in flight, and
// the last step is held for as long as an earlier result still waits in the
// output register. Each chain keeps a running sum that a shift adjusts by
// adding the entering value and subtracting the one that falls off the end;
// since every mean covers the whole window, the order of entries does not
// matter. While any short-chain cell holds zero (including a long mean that
// truncates to zero) the reading is the configured default and default_used
// is set. All cells clear at reset, so no clearing pass is needed. The
// default reading sits at byte address 0 of the APB port and resets to 220 V.
// ----------------------------------------------------------------------------
`include "two_stage_moving_average_unit_macros.svh"

module two_stage_moving_average_unit import tsma_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,

	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic                     opcode,
	input  logic [SAMPLE_BITS-1:0]   sample,

	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [SAMPLE_BITS-1:0]   reading,
	output logic                     default_used
);

	localparam logic [LONG_SUM_BITS-1:0] LONG_SUM_MAX =
		LONG_SUM_BITS'(LONG_WINDOW * ((2 ** SAMPLE_BITS) - 1));

	logic [CFG_READING_BITS-1:0] default_reading;

	tsma_state_t state_q;

	logic cmd_fire;
	logic push_fire;
	logic read_fire;

	sample_t long_d [LONG_WINDOW];
	sample_t long_q [LONG_WINDOW];

	sample_t short_d [SHORT_WINDOW];
	sample_t short_q [SHORT_WINDOW];
	logic [SHORT_WINDOW-1:0] short_zero;
	logic short_shift;

	logic [LONG_SUM_BITS-1:0]   long_sum_q;
	logic [SHORT_SUM_BITS-1:0]  short_sum_q;
	logic [LONG_PROD_BITS-1:0]  long_prod_q;
	logic [SHORT_PROD_BITS-1:0] short_prod_q;
	sample_t                    long_mean;
	logic                       any_zero_q;

	logic    rsp_valid_q;
	sample_t reading_q;
	logic    default_used_q;
	logic    rsp_load;

	// Configuration registers.
	tsma_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.default_reading (default_reading)
	);

	// The command side is open only while no read is being worked on.
	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign push_fire = cmd_fire && (opcode == OP_PUSH);
	assign read_fire = cmd_fire && (opcode == OP_READ);

	// Long chain: the newest sample enters cell 0 and the oldest leaves the
	// last cell on every push.
	assign long_d[0] = sample;
	for (genvar g = 1; g < LONG_WINDOW; g++) begin : g_long_link
		assign long_d[g] = long_q[g-1];
	end

	for (genvar g = 0; g < LONG_WINDOW; g++) begin : g_long
		tsma_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (push_fire),
			.d      (long_d[g]),
			.q      (long_q[g])
		);
	end

	// The long mean is the upper part of the reciprocal product.
	assign long_mean   = long_prod_q[LONG_SHIFT +: SAMPLE_BITS];
	assign short_shift = (state_q == ST_SHIFT);

	// Short chain: each read shifts in one long mean.
	assign short_d[0] = long_mean;
	for (genvar g = 1; g < SHORT_WINDOW; g++) begin : g_short_link
		assign short_d[g] = short_q[g-1];
	end

	for (genvar g = 0; g < SHORT_WINDOW; g++) begin : g_short
		tsma_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (short_shift),
			.d      (short_d[g]),
			.q      (short_q[g])
		);
		assign short_zero[g] = (short_q[g] == '0);
	end

	// Running sums follow the chains. The entry falling off is always part
	// of the sum, so the subtraction never wraps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_sum_q  <= '0;
			short_sum_q <= '0;
		end else begin
			if (push_fire) begin
				long_sum_q <= long_sum_q + LONG_SUM_BITS'(sample)
					- LONG_SUM_BITS'(long_q[LONG_WINDOW-1]);
			end
			if (short_shift) begin
				short_sum_q <= short_sum_q + SHORT_SUM_BITS'(long_mean)
					- SHORT_SUM_BITS'(short_q[SHORT_WINDOW-1]);
			end
		end
	end

	// Read sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (read_fire) begin
						state_q <= ST_LMUL;
					end
				end
				ST_LMUL:  state_q <= ST_SHIFT;
				ST_SHIFT: state_q <= ST_SMUL;
				ST_SMUL:  state_q <= ST_DONE;
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Reciprocal multiplies, one per stage, each registered.
	always_ff @(posedge clk) begin
		if (state_q == ST_LMUL) begin
			long_prod_q <= LONG_PROD_BITS'(long_sum_q) * LONG_PROD_BITS'(LONG_RECIP);
		end
		if (state_q == ST_SMUL) begin
			short_prod_q <= SHORT_PROD_BITS'(short_sum_q)
				* SHORT_PROD_BITS'(SHORT_RECIP);
			any_zero_q   <= |short_zero;
		end
	end

	// Output register. A finished result loads once the slot is free or
	// being emptied in the same cycle.
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			if (any_zero_q) begin
				reading_q      <= SAMPLE_BITS'(default_reading);
				default_used_q <= 1'b1;
			end else begin
				reading_q      <= short_prod_q[SHORT_SHIFT +: SAMPLE_BITS];
				default_used_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign reading      = reading_q;
	assign default_used = default_used_q;

	// A new result appears only out of the final sequencer state.
	`TSMA_ASSERT_IMPL(a_rsp_from_done, clk, arst_n, rsp_valid_q && !$past(rsp_valid_q), $past(state_q == ST_DONE))
	// A blocked result keeps the sequencer waiting.
	`TSMA_ASSERT_NEXT(a_done_holds, clk, arst_n, (state_q == ST_DONE) && rsp_valid_q && rsp_stall, state_q == ST_DONE)
	// Pushes never disturb the short chain.
	`TSMA_ASSERT_NEXT(a_push_keeps_short, clk, arst_n, push_fire, $stable(short_sum_q))
	// The long running sum stays within what the window can hold.
	`TSMA_ASSERT_IMPL(a_long_sum_bound, clk, arst_n, 1'b1, long_sum_q <= LONG_SUM_MAX)

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the two-stage moving average unit. A directed
// table and then random command traffic drive the command port. A predictor
// of both filter rings in the testbench works out every filtered reading,
// and each reading that leaves the unit is checked against it. The default
// reading register is written and read back over APB between phases.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tsma_pkg::*;

	// Filter geometry and constants as the predictor sees them.
	localparam int LONG_TAPS  = 50;
	localparam int SHORT_TAPS = 10;
	localparam int unsigned READING_MAX = 65535;
	localparam logic [15:0] RESET_DEFAULT_READING = 16'd14080;

	// Register map: the default reading is register 0; address 4 holds nothing.
	localparam logic [CFG_ADDR_BITS-1:0] ADDR_DEFAULT_READING =
		CFG_ADDR_BITS'(4 * CFG_IDX_DEFAULT_READING);
	localparam logic [CFG_ADDR_BITS-1:0] ADDR_UNUSED          = 3'd4;

	// Run control.
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 400000;

	// One filtered reading as it leaves the unit.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] value;
		logic                   dflt;
	} filtered_t;

	// One row of the directed table. A row repeats its command reps times.
	// Where fixed is set, the reading is typed in rather than predicted.
	typedef struct packed {
		logic                   op;
		logic [SAMPLE_BITS-1:0] smp;
		logic [7:0]             reps;
		logic                   fixed;
		logic [SAMPLE_BITS-1:0] fixed_value;
		logic                   fixed_dflt;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 16;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// Right after reset the long ring is all zeros, so its mean is zero.
		'{OP_READ, 16'h0000, 8'd1,  1'b1, 16'd14080, 1'b1},
		// A lone sample of 49 averages to 49/50, which truncates to zero.
		'{OP_PUSH, 16'd49,   8'd1,  1'b0, 16'd0,     1'b0},
		'{OP_READ, 16'h0000, 8'd1,  1'b1, 16'd14080, 1'b1},
		// Fill the long ring with the largest sample.
		'{OP_PUSH, 16'hFFFF, 8'd50, 1'b0, 16'd0,     1'b0},
		// Nine reads leave one zero entry in the short ring: still default.
		'{OP_READ, 16'h0000, 8'd9,  1'b1, 16'd14080, 1'b1},
		// The tenth read replaces the last zero: full-scale reading. The
		// sample field is ignored on a read, so it carries all ones here.
		'{OP_READ, 16'hFFFF, 8'd1,  1'b1, 16'd65535, 1'b0},
		// Empty the long ring again; its mean becomes a zero short entry.
		'{OP_PUSH, 16'h0000, 8'd50, 1'b0, 16'd0,     1'b0},
		'{OP_READ, 16'h0000, 8'd1,  1'b1, 16'd14080, 1'b1},
		// Smallest nonzero long mean.
		'{OP_PUSH, 16'h0001, 8'd50, 1'b0, 16'd0,     1'b0},
		'{OP_READ, 16'h5A5A, 8'd10, 1'b0, 16'd0,     1'b0},
		// Alternating bit patterns around mid scale.
		'{OP_PUSH, 16'h8000, 8'd1,  1'b0, 16'd0,     1'b0},
		'{OP_PUSH, 16'h7FFF, 8'd1,  1'b0, 16'd0,     1'b0},
		'{OP_READ, 16'h0000, 8'd1,  1'b0, 16'd0,     1'b0},
		'{OP_PUSH, 16'hAAAA, 8'd3,  1'b0, 16'd0,     1'b0},
		'{OP_PUSH, 16'h5555, 8'd3,  1'b0, 16'd0,     1'b0},
		'{OP_READ, 16'h0000, 8'd2,  1'b0, 16'd0,     1'b0}
	};

	// Every input of the unit starts at a known value.
	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     psel      = 1'b0;
	logic                     penable   = 1'b0;
	logic                     pwrite    = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr     = '0;
	logic [CFG_DATA_BITS-1:0] pwdata    = '0;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     cmd_valid = 1'b0;
	logic                     cmd_stall;
	logic                     opcode    = OP_PUSH;
	logic [SAMPLE_BITS-1:0]   sample    = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic [SAMPLE_BITS-1:0]   reading;
	logic                     default_used;

	// Predictor state: both rings, their write positions and the register.
	logic [SAMPLE_BITS-1:0] long_taps  [LONG_TAPS];
	logic [SAMPLE_BITS-1:0] short_taps [SHORT_TAPS];
	int unsigned            long_wr;
	int unsigned            short_wr;
	logic [15:0]            cfg_default_reading;

	// Readings predicted for accepted read transactions, oldest first.
	filtered_t pending_readings [$];

	// Idle and stall rates of the current phase, in percent of cycles.
	int cmd_idle_pct  = 0;
	int rsp_stall_pct = 0;

	// The long receiver hold-off runs in its own process.
	event hold_start;
	logic rsp_hold = 1'b0;

	int mismatch_count = 0;
	int cycle_count    = 0;

	two_stage_moving_average_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.opcode       (opcode),
		.sample       (sample),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.reading      (reading),
		.default_used (default_used)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard limit on the run, in clock cycles.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Only the first few mismatches are printed; all of them are counted.
	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// Advance the predicted filter by one accepted command. A push only
	// writes the long ring. A read folds the long mean into the short ring
	// and returns the reading, which is the default while any short entry
	// is zero.
	function automatic bit advance_filter(input logic op, input logic [SAMPLE_BITS-1:0] smp,
			output filtered_t res);
		int unsigned total;
		logic [SAMPLE_BITS-1:0] mean;
		bit saw_zero;
		res = '0;
		if (op == OP_PUSH) begin
			long_taps[long_wr] = smp;
			long_wr = (long_wr == LONG_TAPS - 1) ? 0 : long_wr + 1;
			return 1'b0;
		end
		total = 0;
		foreach (long_taps[i])
			total += long_taps[i];
		mean = SAMPLE_BITS'(total / LONG_TAPS);
		short_taps[short_wr] = mean;
		short_wr = (short_wr == SHORT_TAPS - 1) ? 0 : short_wr + 1;
		total = 0;
		saw_zero = 1'b0;
		foreach (short_taps[i]) begin
			if (short_taps[i] == '0)
				saw_zero = 1'b1;
			total += short_taps[i];
		end
		if (saw_zero) begin
			res.value = cfg_default_reading;
			res.dflt  = 1'b1;
		end else begin
			total = total / SHORT_TAPS;
			res.value = (total > READING_MAX) ? SAMPLE_BITS'(READING_MAX) : SAMPLE_BITS'(total);
			res.dflt  = 1'b0;
		end
		return 1'b1;
	endfunction

	// Offer one command transaction, maybe after some idle cycles, and wait
	// for the unit to take it. Called right after a rising edge. A valid
	// that stays high is only reassigned, never dropped and raised again.
	task automatic drive_transaction(input logic op, input logic [SAMPLE_BITS-1:0] smp,
			input bit fixed, input filtered_t fixed_res);
		filtered_t res;
		if (cmd_idle_pct != 0 && $urandom_range(99) < cmd_idle_pct) begin
			cmd_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < cmd_idle_pct);
		end
		cmd_valid <= 1'b1;
		opcode    <= op;
		sample    <= smp;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		// Accepted at this edge: update the prediction in command order.
		if (advance_filter(op, smp, res))
			pending_readings.push_back(fixed ? fixed_res : res);
	endtask

	// APB write: setup phase, then access phase until pready, then the bus
	// returns to idle.
	task automatic apb_write(input logic [CFG_ADDR_BITS-1:0] addr,
			input logic [CFG_DATA_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		// Writes to any address but the register are ignored; only the low
		// 16 bits are kept.
		if (addr == ADDR_DEFAULT_READING)
			cfg_default_reading = data[15:0];
	endtask

	// APB read of the default reading register, compared with the model copy.
	task automatic check_default_reading_reg();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_DEFAULT_READING;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== CFG_DATA_BITS'(cfg_default_reading))
			note_mismatch($sformatf("prdata expected %0d, got %0d",
				cfg_default_reading, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Stop offering commands, let every predicted reading arrive and the
	// unit go quiet, then write a register and read the default back.
	task automatic settle_and_configure(input logic [CFG_ADDR_BITS-1:0] addr,
			input logic [CFG_DATA_BITS-1:0] data);
		cmd_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		apb_write(addr, data);
		check_default_reading_reg();
	endtask

	// Random command traffic. Samples come in stretches of one character:
	// full-range values in half of the stretches, and in the rest tiny values,
	// rail-to-rail extremes or plain zeros, so that long means near zero
	// and the default reading keep coming back.
	task automatic run_phase(input int items, input int idle_pct, input int stall_pct,
			input int read_pct);
		int regime;
		int regime_left;
		logic op;
		logic [SAMPLE_BITS-1:0] smp;
		regime        = 0;
		regime_left   = 0;
		cmd_idle_pct  = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (items) begin
			if (regime_left == 0) begin
				regime      = $urandom_range(5);
				regime_left = $urandom_range(120, 20);
			end
			regime_left--;
			op = ($urandom_range(99) < read_pct) ? OP_READ : OP_PUSH;
			case (regime)
				3:       smp = SAMPLE_BITS'($urandom_range(60));
				4:       smp = $urandom_range(1) ? '1 : '0;
				5:       smp = '0;
				default: smp = SAMPLE_BITS'($urandom);
			endcase
			drive_transaction(op, smp, 1'b0, '0);
		end
	endtask

	// Receiver: check each accepted reading against the oldest prediction,
	// then pick the stall for the next cycle. Outputs are taken as they
	// stood before the edge.
	always @(posedge clk) begin : rsp_check
		filtered_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_readings.size() == 0) begin
				note_mismatch($sformatf("unexpected reading %0d, default_used %0b",
					reading, default_used));
			end else begin
				want = pending_readings.pop_front();
				if (reading !== want.value)
					note_mismatch($sformatf("reading expected %0d, got %0d",
						want.value, reading));
				if (default_used !== want.dflt)
					note_mismatch($sformatf("default_used expected %0b, got %0b",
						want.dflt, default_used));
			end
		end
		rsp_stall <= rsp_hold || ($urandom_range(99) < rsp_stall_pct);
	end

	// Long receiver hold-off: the output side stays stalled while the sender
	// keeps offering commands, so the output register fills and the unit has
	// to stall its command input.
	initial begin
		forever begin
			@(hold_start);
			rsp_hold <= 1'b1;
			repeat (HOLD_CYCLES)
				@(posedge clk);
			rsp_hold <= 1'b0;
		end
	end

	// Main sequence.
	initial begin
		foreach (long_taps[i])
			long_taps[i] = '0;
		foreach (short_taps[i])
			short_taps[i] = '0;
		long_wr             = 0;
		short_wr            = 0;
		cfg_default_reading = RESET_DEFAULT_READING;

		// Reset once, released at a clock edge.
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_default_reading_reg();

		// Directed table with the reset default and no idling.
		foreach (directed_rows[r])
			repeat (directed_rows[r].reps)
				drive_transaction(directed_rows[r].op, directed_rows[r].smp,
					directed_rows[r].fixed,
					filtered_t'{directed_rows[r].fixed_value, directed_rows[r].fixed_dflt});

		// A write to an address with no register must leave the default as is.
		settle_and_configure(ADDR_UNUSED, 32'hFFFF_FFFF);

		// Default of zero (upper bits of the write are dropped), no idling.
		settle_and_configure(ADDR_DEFAULT_READING, 32'hABCD_0000);
		run_phase(200, 0, 0, 25);

		// Full-scale default, sender idle half the time.
		settle_and_configure(ADDR_DEFAULT_READING, 32'h0000_FFFF);
		run_phase(200, 50, 0, 25);

		// Random default with junk in the upper bits, receiver stalling half
		// the time.
		settle_and_configure(ADDR_DEFAULT_READING, $urandom);
		run_phase(200, 0, 50, 25);

		// Random default, both sides idling a little.
		settle_and_configure(ADDR_DEFAULT_READING,
			{16'h0000, SAMPLE_BITS'($urandom)});
		run_phase(200, 14, 14, 25);

		// Backpressure: mostly reads while the receiver holds off for a long
		// stretch, so the unit fills up and stalls the command side.
		settle_and_configure(ADDR_DEFAULT_READING, 32'hFFFF_0001);
		-> hold_start;
		run_phase(200, 0, 0, 60);

		// Back to the reset default, light idling on both sides.
		settle_and_configure(ADDR_DEFAULT_READING, 32'(RESET_DEFAULT_READING));
		run_phase(150, 14, 14, 25);

		// Wait for every predicted reading, then a few quiet cycles in which
		// any stray result would still be caught.
		cmd_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
